// File: rtl/gpm_pkg.sv
// Shared types, character codes and path-normalizer functions for the glob path matcher.
// Used by gpm_comp, gpm_nfa and glob_path_matcher; depends on nothing else.
`timescale 1ns / 1ps

package gpm_pkg;

  // Input item kinds carried in the slave tuser field.
  localparam logic [1:0] MODE_PAT  = 2'd0;
  localparam logic [1:0] MODE_PATH = 2'd1;
  localparam logic [1:0] MODE_END  = 2'd2;
  localparam logic [1:0] MODE_CLR  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CASE_FOLD = 2'd0;
  localparam logic [1:0] CFG_NORMALIZE = 2'd1;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;

  typedef enum logic [2:0] {
    TK_LIT,
    TK_ONE,
    TK_STAR,
    TK_GS_ENTRY,
    TK_GS_LOOP
  } kind_e;

  // Normalizer state: up to three bytes held while the drive prefix is undecided.
  typedef struct packed {
    logic [2:0][7:0] la;
    logic [1:0]      cnt;
    logic            front_done;
    logic            pending;
  } norm_st_t;

  // One normalizer step: new state and up to four bytes emitted.
  typedef struct packed {
    norm_st_t        st;
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } norm_res_t;

  // Automaton controls issued by the top level.
  typedef struct packed {
    logic init;
    logic step;
    logic fold;
    logic subtree;
  } nfa_ctl_t;

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic [7:0] to_low(logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
  endfunction

  function automatic kind_e kind_of(logic [7:0] c);
    if (c == CH_STAR) return TK_STAR;
    if (c == CH_QMARK) return TK_ONE;
    return TK_LIT;
  endfunction

  function automatic norm_res_t nrm_emit(norm_res_t r, logic [7:0] c);
    norm_res_t o;
    o = r;
    if (o.n < 3'd4) o.b[o.n[1:0]] = c;
    o.n = o.n + 3'd1;
    return o;
  endfunction

  function automatic norm_res_t nrm_flush(norm_res_t r);
    norm_res_t  o;
    logic [1:0] k;
    logic [1:0] j;
    o = r;
    k = r.st.cnt;
    j = 2'd0;
    if ((k >= 2'd2) && (o.st.la[0] == CH_SLASH) && is_alpha(o.st.la[1]) &&
        ((k == 2'd2) || (o.st.la[2] == CH_SLASH))) begin
      o = nrm_emit(o, to_low(o.st.la[1]));
      o = nrm_emit(o, CH_COLON);
      j = 2'd2;
    end else if ((k >= 2'd2) && is_alpha(o.st.la[0]) && (o.st.la[1] == CH_COLON)) begin
      o = nrm_emit(o, to_low(o.st.la[0]));
      j = 2'd1;
    end
    for (int m = 0; m < 3; m++) begin
      if ((2'(m) >= j) && (2'(m) < k)) o = nrm_emit(o, o.st.la[m]);
    end
    o.st.cnt        = 2'd0;
    o.st.front_done = 1'b1;
    return o;
  endfunction

  function automatic norm_res_t nrm_put(norm_res_t r, logic [7:0] c);
    norm_res_t o;
    o = r;
    if (o.st.front_done) begin
      o = nrm_emit(o, c);
    end else begin
      if (o.st.cnt < 2'd3) begin
        o.st.la[o.st.cnt] = c;
        o.st.cnt = o.st.cnt + 2'd1;
      end
      if (o.st.cnt == 2'd3) o = nrm_flush(o);
    end
    return o;
  endfunction

  function automatic norm_res_t nrm_push(norm_st_t st, logic [7:0] c);
    norm_res_t  r;
    logic [7:0] bb;
    r.st = st;
    r.b  = '0;
    r.n  = 3'd0;
    bb   = (c == CH_BSLASH) ? CH_SLASH : c;
    if (bb == CH_SLASH) begin
      r.st.pending = 1'b1;
    end else begin
      if (r.st.pending) begin
        r = nrm_put(r, CH_SLASH);
        r.st.pending = 1'b0;
      end
      r = nrm_put(r, bb);
    end
    return r;
  endfunction

  function automatic norm_res_t nrm_finish(norm_st_t st);
    norm_res_t r;
    r.st = st;
    r.b  = '0;
    r.n  = 3'd0;
    if (r.st.pending && !r.st.front_done && (r.st.cnt == 2'd0)) r = nrm_put(r, CH_SLASH);
    if (!r.st.front_done) r = nrm_flush(r);
    r.st = '0;
    return r;
  endfunction

endpackage

// File: rtl/glob_path_matcher.sv
// Glob path matcher top level: stream ports, item register, path normalizer and result register.
// Depends on gpm_pkg, gpm_comp and gpm_nfa.
`timescale 1ns / 1ps

// Pattern bytes (tuser mode 0) are appended to a store of MaxPattern bytes; mode 3 clears it.
// Path bytes (mode 1) are matched against the pattern by a position automaton that advances
// one normalized byte per cycle, and end of path (mode 2) yields one beat on the master side
// with the match bit and the pattern overflow flag. When normalization is on, a path beat
// that turns into more than one normalized byte holds the input until the queue is down to
// the byte being consumed, since the automaton takes a single byte per cycle. The first path
// or end beat after a pattern change or a finished path starts a compile pass, which reads
// the stored pattern bytes one at a time through the single read port of the pattern memory
// and, with normalization on, also emits each normalized pattern byte and the final flush;
// that beat waits until the pass is done. End of path loads its result into the output
// register once the queued normalized bytes are consumed and the register is free, and the
// beat behind it waits until the result sits in the output register. The case-folding and
// normalize_paths settings are sampled at the start of each path.
module glob_path_matcher import gpm_pkg::*; #(
  parameter int MaxPattern = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0] s_axis_tuser,   // [1:0] mode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] matched, [7:1] zero
  output logic       m_axis_tuser,   // [0] pattern_overflow
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic       cfg_data_i
);

  localparam int LW = $clog2(MaxPattern + 1);

  logic            fold_cfg_q, norm_cfg_q;
  logic            use_fold_q, use_norm_q;
  logic            it_vld_q, it_vld_d;
  logic [1:0]      it_mode_q;
  logic [7:0]      it_byte_q;
  logic            in_path_q, in_path_d;
  logic            end_pend_q, end_pend_d;
  norm_st_t        pst_q, pst_d;
  logic [3:0][7:0] q_b_q, q_b_d;
  logic [2:0]      q_n_q, q_n_d;
  logic            out_vld_q, out_match_q, out_ovf_q;

  logic            eng_ok, need_start, start_cmp, item_done;
  logic            do_pat, do_clr, do_path, do_end;
  logic            pop, out_load;
  norm_res_t       nr_push, nr_fin;

  logic                        cmp_busy, cmp_done;
  logic [MaxPattern-1:0][7:0]  cmp_pat;
  kind_e [MaxPattern-1:0]      cmp_kind;
  logic [LW-1:0]               cmp_clen;
  logic                        cmp_ends, cmp_gs, cmp_ovf, cmp_sub;
  nfa_ctl_t                    nfa_ctl;
  logic                        nfa_match;

  // The input register frees as soon as its beat is retired, so a new beat enters each cycle
  // unless the held beat is stalled. A queue of at most four normalized bytes feeds the automaton;
  // a path beat is taken once the queue holds no more than the byte being consumed in this cycle.
  assign need_start = ((it_mode_q == MODE_PATH) || (it_mode_q == MODE_END)) && !in_path_q;
  assign eng_ok     = it_vld_q && (q_n_q <= 3'd1) && !end_pend_q && !cmp_busy;
  assign start_cmp  = eng_ok && need_start;
  assign item_done  = eng_ok && !need_start;
  assign do_pat     = item_done && (it_mode_q == MODE_PAT);
  assign do_clr     = item_done && (it_mode_q == MODE_CLR);
  assign do_path    = item_done && (it_mode_q == MODE_PATH);
  assign do_end     = item_done && (it_mode_q == MODE_END);
  assign pop        = (q_n_q != 3'd0);
  assign out_load   = end_pend_q && (q_n_q == 3'd0) && (!out_vld_q || m_axis_tready);

  assign s_axis_tready = !it_vld_q || item_done;
  assign cfg_ready_o   = 1'b1;

  assign nr_push = nrm_push(pst_q, it_byte_q);
  assign nr_fin  = nrm_finish(pst_q);

  always_comb begin
    it_vld_d   = it_vld_q;
    in_path_d  = in_path_q;
    end_pend_d = end_pend_q;
    pst_d      = pst_q;
    q_b_d      = q_b_q;
    q_n_d      = q_n_q;
    if (s_axis_tready) it_vld_d = s_axis_tvalid;
    if (pop) begin
      q_b_d = q_b_q >> 8;
      q_n_d = q_n_q - 3'd1;
    end
    if (do_pat || do_clr || start_cmp) q_n_d = 3'd0;
    if (start_cmp) pst_d = '0;
    if (do_path) begin
      if (use_norm_q) begin
        pst_d = nr_push.st;
        q_b_d = nr_push.b;
        q_n_d = nr_push.n;
      end else begin
        q_b_d = {24'd0, it_byte_q};
        q_n_d = 3'd1;
      end
    end
    if (do_end) begin
      end_pend_d = 1'b1;
      if (use_norm_q) begin
        pst_d = nr_fin.st;
        q_b_d = nr_fin.b;
        q_n_d = nr_fin.n;
      end
    end
    if (cmp_done) in_path_d = 1'b1;
    if (do_pat || do_clr) in_path_d = 1'b0;
    if (out_load) begin
      in_path_d  = 1'b0;
      end_pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_cfg_q <= 1'b0;
      norm_cfg_q <= 1'b0;
      use_fold_q <= 1'b0;
      use_norm_q <= 1'b0;
      it_vld_q   <= 1'b0;
      in_path_q  <= 1'b0;
      end_pend_q <= 1'b0;
      pst_q      <= '0;
      q_n_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_CASE_FOLD) fold_cfg_q <= cfg_data_i;
        if (cfg_index_i == CFG_NORMALIZE) norm_cfg_q <= cfg_data_i;
      end
      if (start_cmp) begin
        use_fold_q <= fold_cfg_q;
        use_norm_q <= norm_cfg_q;
      end
      it_vld_q   <= it_vld_d;
      in_path_q  <= in_path_d;
      end_pend_q <= end_pend_d;
      pst_q      <= pst_d;
      q_n_q      <= q_n_d;
      if (out_load) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      it_mode_q <= s_axis_tuser;
      it_byte_q <= s_axis_tdata;
    end
    q_b_q <= q_b_d;
    if (out_load) begin
      out_match_q <= nfa_match;
      out_ovf_q   <= cmp_ovf;
    end
  end

  gpm_comp #(
    .MaxPattern (MaxPattern)
  ) u_comp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (do_pat),
    .wr_byte_i    (it_byte_q),
    .clr_i        (do_clr),
    .start_i      (start_cmp),
    .use_norm_i   (start_cmp ? norm_cfg_q : use_norm_q),
    .busy_o       (cmp_busy),
    .done_o       (cmp_done),
    .pat_o        (cmp_pat),
    .kind_o       (cmp_kind),
    .clen_o       (cmp_clen),
    .ends_slash_o (cmp_ends),
    .gs_tail_o    (cmp_gs),
    .overflow_o   (cmp_ovf),
    .subtree_o    (cmp_sub)
  );

  assign nfa_ctl.init    = cmp_done;
  assign nfa_ctl.step    = pop;
  assign nfa_ctl.fold    = use_fold_q;
  assign nfa_ctl.subtree = cmp_sub;

  gpm_nfa #(
    .MaxPattern (MaxPattern)
  ) u_nfa (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (nfa_ctl),
    .byte_i       (q_b_q[0]),
    .pat_i        (cmp_pat),
    .kind_i       (cmp_kind),
    .clen_i       (cmp_clen),
    .ends_slash_i (cmp_ends),
    .gs_tail_i    (cmp_gs),
    .matched_o    (nfa_match)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_match_q};
  assign m_axis_tuser  = out_ovf_q;

  // No beat is retired while the compiler owns the pattern store.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmp_busy |-> !item_done)
    else $error("beat retired during compile");

  // An end of path waiting for its result always belongs to a live path.
  assert property (@(posedge clk_i) disable iff (!rst_ni) end_pend_q |-> in_path_q)
    else $error("pending end without a path");

  // The normalized byte queue never grows past its four entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_n_q <= 3'd4)
    else $error("byte queue overrun");

  // A new result beat only ever follows a pending end of path.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(m_axis_tvalid) |-> $past(end_pend_q))
    else $error("result without end of path");

endmodule

// File: rtl/gpm_comp.sv
// Pattern store and compiler: keeps raw pattern bytes and builds the token table at path start.
// Depends on gpm_pkg for the normalizer functions and token kinds.
`timescale 1ns / 1ps

module gpm_comp import gpm_pkg::*; #(
  parameter int MaxPattern = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_i,
  input  logic [7:0]                          wr_byte_i,
  input  logic                                clr_i,
  input  logic                                start_i,
  input  logic                                use_norm_i,
  output logic                                busy_o,
  output logic                                done_o,
  output logic [MaxPattern-1:0][7:0]          pat_o,
  output kind_e [MaxPattern-1:0]              kind_o,
  output logic [$clog2(MaxPattern+1)-1:0]     clen_o,
  output logic                                ends_slash_o,
  output logic                                gs_tail_o,
  output logic                                overflow_o,
  output logic                                subtree_o
);

  localparam int AW = $clog2(MaxPattern);
  localparam int LW = $clog2(MaxPattern + 1);

  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_READ  = 3'd1;
  localparam logic [2:0] C_PUSH  = 3'd2;
  localparam logic [2:0] C_DRAIN = 3'd3;
  localparam logic [2:0] C_FIN   = 3'd4;
  localparam logic [2:0] C_DONE  = 3'd5;

  logic [7:0]            mem_q [MaxPattern];
  logic [7:0]            rd_q;
  logic [LW-1:0]         plen_q, plen_d;
  logic                  ovf_q, ovf_d;
  logic                  sub_q, sub_d;

  logic [2:0]            st_q, st_d;
  logic [LW-1:0]         cidx_q, cidx_d;
  norm_st_t              nst_q, nst_d;
  logic [3:0][7:0]       cb_q, cb_d;
  logic [2:0]            cn_q, cn_d;
  logic [2:0]            ck_q, ck_d;
  logic                  fin_q, fin_d;
  norm_res_t             nr_push, nr_fin;

  logic [MaxPattern-1:0][7:0] pat_q;
  kind_e [MaxPattern-1:0]     kind_q;
  logic [LW-1:0]         clen_q, clen_d;
  logic                  unp_q, unp_d;
  logic                  ends_q, ends_d;
  logic                  gs_q, gs_d;
  logic                  app_v;
  logic [7:0]            app_b;
  logic                  can_app;
  logic                  pair;
  logic [AW-1:0]         aidx;

  // Raw pattern memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_i && (plen_q < LW'(MaxPattern))) mem_q[plen_q[AW-1:0]] <= wr_byte_i;
    rd_q <= mem_q[cidx_q[AW-1:0]];
  end

  always_comb begin
    plen_d = plen_q;
    ovf_d  = ovf_q;
    sub_d  = sub_q;
    if (clr_i) begin
      plen_d = '0;
      ovf_d  = 1'b0;
      sub_d  = 1'b0;
    end else if (wr_i) begin
      if (plen_q < LW'(MaxPattern)) plen_d = plen_q + LW'(1);
      else ovf_d = 1'b1;
      sub_d = (wr_byte_i == CH_SLASH);
    end
  end

  always_comb begin
    st_d    = st_q;
    cidx_d  = cidx_q;
    nst_d   = nst_q;
    cb_d    = cb_q;
    cn_d    = cn_q;
    ck_d    = ck_q;
    fin_d   = fin_q;
    app_v   = 1'b0;
    app_b   = rd_q;
    nr_push = nrm_push(nst_q, rd_q);
    nr_fin  = nrm_finish(nst_q);
    unique case (st_q)
      C_IDLE: begin
        if (start_i) begin
          st_d   = C_READ;
          cidx_d = '0;
          nst_d  = '0;
          fin_d  = 1'b0;
        end
      end
      C_READ: begin
        if (cidx_q < plen_q) st_d = C_PUSH;
        else if (use_norm_i) st_d = C_FIN;
        else st_d = C_DONE;
      end
      C_PUSH: begin
        cidx_d = cidx_q + LW'(1);
        if (use_norm_i) begin
          nst_d = nr_push.st;
          cb_d  = nr_push.b;
          cn_d  = nr_push.n;
          ck_d  = 3'd0;
          st_d  = (nr_push.n == 3'd0) ? C_READ : C_DRAIN;
        end else begin
          app_v = 1'b1;
          st_d  = C_READ;
        end
      end
      C_DRAIN: begin
        app_v = 1'b1;
        app_b = cb_q[ck_q[1:0]];
        ck_d  = ck_q + 3'd1;
        if ((ck_q + 3'd1) == cn_q) st_d = fin_q ? C_DONE : C_READ;
      end
      C_FIN: begin
        nst_d = '0;
        cb_d  = nr_fin.b;
        cn_d  = nr_fin.n;
        ck_d  = 3'd0;
        fin_d = 1'b1;
        st_d  = (nr_fin.n == 3'd0) ? C_DONE : C_DRAIN;
      end
      C_DONE: st_d = C_IDLE;
      default: st_d = C_IDLE;
    endcase
  end

  // A second star right behind an unpaired one turns the pair into a globstar.
  assign can_app = app_v && (clen_q < LW'(MaxPattern));
  assign pair    = (app_b == CH_STAR) && unp_q;
  assign aidx    = clen_q[AW-1:0];

  always_comb begin
    clen_d = clen_q;
    unp_d  = unp_q;
    ends_d = ends_q;
    gs_d   = gs_q;
    if (start_i && (st_q == C_IDLE)) begin
      clen_d = '0;
      unp_d  = 1'b0;
      ends_d = 1'b0;
      gs_d   = 1'b0;
    end else if (can_app) begin
      clen_d = clen_q + LW'(1);
      unp_d  = (app_b == CH_STAR) && !pair;
      ends_d = (app_b == CH_SLASH);
      gs_d   = pair;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_app) begin
      pat_q[aidx]  <= app_b;
      kind_q[aidx] <= pair ? TK_GS_LOOP : kind_of(app_b);
      if (pair) kind_q[aidx - AW'(1)] <= TK_GS_ENTRY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0;
      ovf_q  <= 1'b0;
      sub_q  <= 1'b0;
      st_q   <= C_IDLE;
      cidx_q <= '0;
      nst_q  <= '0;
      cn_q   <= '0;
      ck_q   <= '0;
      fin_q  <= 1'b0;
      clen_q <= '0;
      unp_q  <= 1'b0;
      ends_q <= 1'b0;
      gs_q   <= 1'b0;
    end else begin
      plen_q <= plen_d;
      ovf_q  <= ovf_d;
      sub_q  <= sub_d;
      st_q   <= st_d;
      cidx_q <= cidx_d;
      nst_q  <= nst_d;
      cn_q   <= cn_d;
      ck_q   <= ck_d;
      fin_q  <= fin_d;
      clen_q <= clen_d;
      unp_q  <= unp_d;
      ends_q <= ends_d;
      gs_q   <= gs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cb_q <= cb_d;
  end

  assign busy_o       = (st_q != C_IDLE);
  assign done_o       = (st_q == C_DONE);
  assign pat_o        = pat_q;
  assign kind_o       = kind_q;
  assign clen_o       = clen_q;
  assign ends_slash_o = ends_q;
  assign gs_tail_o    = gs_q;
  assign overflow_o   = ovf_q;
  assign subtree_o    = sub_q;

endmodule

// File: rtl/gpm_nfa.sv
// Position automaton: one bit per pattern position, advanced by one path byte per step.
// Depends on gpm_pkg for token kinds, character codes and the control struct.
`timescale 1ns / 1ps

module gpm_nfa import gpm_pkg::*; #(
  parameter int MaxPattern = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  nfa_ctl_t                         ctl_i,
  input  logic [7:0]                       byte_i,
  input  logic [MaxPattern-1:0][7:0]       pat_i,
  input  kind_e [MaxPattern-1:0]           kind_i,
  input  logic [$clog2(MaxPattern+1)-1:0]  clen_i,
  input  logic                             ends_slash_i,
  input  logic                             gs_tail_i,
  output logic                             matched_o
);

  localparam int N  = MaxPattern;
  localparam int LW = $clog2(MaxPattern + 1);

  logic [N:0]   act_q, act_d;
  logic         hit_q, hit_d;
  logic [N:0]   nx, src, cl;
  logic [N:0]   end_mask, tail_mask;
  logic [N-1:0] eps, jump;
  logic         is_sl, pre_hit, post_hit;

  assign is_sl = (byte_i == CH_SLASH);

  always_comb begin
    for (int k = 0; k <= N; k++) begin
      end_mask[k]  = (k == int'(clen_i));
      tail_mask[k] = ((k + 2) == int'(clen_i));
    end
  end

  // Byte step and the epsilon edges of each position.
  always_comb begin
    nx = '0;
    for (int i = 0; i < N; i++) begin
      eps[i]  = (LW'(i) < clen_i) && ((kind_i[i] == TK_STAR) || (kind_i[i] == TK_GS_LOOP) ||
                                     (kind_i[i] == TK_GS_ENTRY));
      jump[i] = 1'b0;
      if (i + 2 < N) begin
        jump[i] = (LW'(i) < clen_i) && (kind_i[i] == TK_GS_ENTRY) &&
                  ((i + 2) < int'(clen_i)) && (pat_i[i+2] == CH_SLASH);
      end
      if (act_q[i] && (LW'(i) < clen_i)) begin
        case (kind_i[i])
          TK_STAR:    if (!is_sl) nx[i] = 1'b1;
          TK_GS_LOOP: nx[i] = 1'b1;
          TK_ONE:     if (!is_sl) nx[i+1] = 1'b1;
          TK_LIT: begin
            if (ctl_i.fold ? (to_low(pat_i[i]) == to_low(byte_i)) : (pat_i[i] == byte_i))
              nx[i+1] = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Forward closure: a carry-style ripple across the positions.
  always_comb begin
    src = ctl_i.init ? {{N{1'b0}}, 1'b1} : nx;
    cl  = src;
    for (int i = 0; i < N; i++) begin
      if (cl[i] && eps[i]) cl[i+1] = 1'b1;
      if (i + 3 <= N) begin
        if (cl[i] && jump[i]) cl[i+3] = 1'b1;
      end
    end
  end

  assign pre_hit  = ctl_i.subtree && !ends_slash_i && |(act_q & end_mask) && is_sl;
  assign post_hit = ctl_i.subtree && ((ends_slash_i && |(cl & end_mask)) ||
                                      (gs_tail_i && |(cl & tail_mask)));

  always_comb begin
    act_d = act_q;
    hit_d = hit_q;
    if (ctl_i.init) begin
      act_d = cl;
      hit_d = post_hit;
    end else if (ctl_i.step) begin
      act_d = cl;
      hit_d = hit_q || pre_hit || post_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= {{N{1'b0}}, 1'b1};
      hit_q <= 1'b0;
    end else begin
      act_q <= act_d;
      hit_q <= hit_d;
    end
  end

  assign matched_o = hit_q || (!ctl_i.subtree && |(act_q & end_mask));

endmodule
